// ===== src/gdad_pkg.sv =====
// shared types, constants and state codes for the date adder
package gdad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADD_W   = 15;
  localparam int ACC_W   = 16;
  localparam int R400_W  = 9;
  localparam int LEN_W   = 5;
  localparam int STEP_W  = 3;

  localparam int MOD_STEPS = 6;

  localparam logic [YEAR_W-1:0]  YEAR_MAX = '1;
  localparam logic [MONTH_W-1:0] JAN      = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEB      = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] APR      = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] JUN      = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] SEP      = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] NOV      = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] DEC      = MONTH_W'(12);

  localparam logic [ACC_W-1:0]  CYCLE_400  = ACC_W'(400);
  localparam logic [R400_W-1:0] R400_LAST  = R400_W'(399);
  localparam logic [R400_W-1:0] CENT_1     = R400_W'(100);
  localparam logic [R400_W-1:0] CENT_2     = R400_W'(200);
  localparam logic [R400_W-1:0] CENT_3     = R400_W'(300);

  localparam logic [LEN_W-1:0] LEN_31   = LEN_W'(31);
  localparam logic [LEN_W-1:0] LEN_30   = LEN_W'(30);
  localparam logic [LEN_W-1:0] LEN_29   = LEN_W'(29);
  localparam logic [LEN_W-1:0] LEN_28   = LEN_W'(28);
  localparam logic [LEN_W-1:0] LEN_NONE = LEN_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DOY,
    ST_ADD,
    ST_WALK,
    ST_OUT
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             borrow;
    logic             zero;
  } alu_res_t;

endpackage

// ===== src/gdad_if.sv =====
// handshake channels for the date adder input and result beats
interface gdad_in_if;
  logic                         valid;
  logic                         ready;
  logic [gdad_pkg::YEAR_W-1:0]  start_year;
  logic [gdad_pkg::MONTH_W-1:0] start_month;
  logic [gdad_pkg::DAY_W-1:0]   start_day;
  logic [gdad_pkg::ADD_W-1:0]   days_to_add;

  modport source (output valid, start_year, start_month, start_day, days_to_add,
                  input ready);
  modport sink (input valid, start_year, start_month, start_day, days_to_add,
                output ready);
endinterface

interface gdad_out_if;
  logic                         valid;
  logic                         ready;
  logic [gdad_pkg::YEAR_W-1:0]  result_year;
  logic [gdad_pkg::MONTH_W-1:0] result_month;
  logic [gdad_pkg::DAY_W-1:0]   result_day;

  modport source (output valid, result_year, result_month, result_day, input ready);
  modport sink (input valid, result_year, result_month, result_day, output ready);
endinterface

// ===== src/gdad_alu.sv =====
// shared add/subtract unit with borrow and zero flags
module gdad_alu (
  input  gdad_pkg::alu_op_e              op_i,
  input  logic [gdad_pkg::ACC_W-1:0]     a_i,
  input  logic [gdad_pkg::ACC_W-1:0]     b_i,
  output gdad_pkg::alu_res_t             res_o
);
  import gdad_pkg::*;

  logic [ACC_W:0] wide;

  always_comb begin
    case (op_i)
      ALU_ADD: wide = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: wide = {1'b0, a_i} - {1'b0, b_i};
      default: wide = {1'b0, a_i};
    endcase
    res_o.res    = wide[ACC_W-1:0];
    res_o.borrow = (op_i == ALU_SUB) && wide[ACC_W];
    res_o.zero   = (wide[ACC_W-1:0] == '0);
  end

endmodule

// ===== src/gdad_mlen.sv =====
// month length lookup with gregorian leap rule
module gdad_mlen (
  input  logic [gdad_pkg::MONTH_W-1:0] month_i,
  input  logic [1:0]                   year_lsb_i,
  input  logic [gdad_pkg::R400_W-1:0]  r400_i,
  output logic [gdad_pkg::LEN_W-1:0]   len_o
);
  import gdad_pkg::*;

  logic leap;

  always_comb begin
    leap = (r400_i == '0) ||
           ((year_lsb_i == 2'b00) && (r400_i != CENT_1) && (r400_i != CENT_2) &&
            (r400_i != CENT_3));
    if ((month_i < JAN) || (month_i > DEC)) begin
      len_o = LEN_NONE;
    end else if (month_i == FEB) begin
      len_o = leap ? LEN_29 : LEN_28;
    end else if ((month_i == APR) || (month_i == JUN) || (month_i == SEP) ||
                 (month_i == NOV)) begin
      len_o = LEN_30;
    end else begin
      len_o = LEN_31;
    end
  end

endmodule

// ===== src/gregorian_date_add_days.sv =====
// Adds a day count to a Gregorian date, one item at a time. After a beat is
// taken the block reduces the year modulo 400 by restoring subtraction, sums
// the lengths of the months before the start month (up to 14) one at a time,
// adds the count, then walks forward one month per cycle through the shared
// adder until the running count fits the month. The month walk on the single
// adder dominates the time per item. The input is ready only while idle, and
// the result is held until the sink takes it.
module gregorian_date_add_days (
  input logic     clk_i,
  input logic     rst_ni,
  gdad_in_if.sink  in_i,
  gdad_out_if.source out_o
);
  import gdad_pkg::*;

  state_e state_q, state_d;

  logic [YEAR_W-1:0]  year_q, year_d;
  logic [MONTH_W-1:0] smonth_q, smonth_d;
  logic [DAY_W-1:0]   sday_q, sday_d;
  logic [ADD_W-1:0]   add_q, add_d;
  logic [MONTH_W-1:0] m_q, m_d;
  logic [R400_W-1:0]  r400_q, r400_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [STEP_W-1:0]  step_q, step_d;

  alu_op_e          alu_op;
  logic [ACC_W-1:0] alu_b;
  alu_res_t         alu_res;
  logic [LEN_W-1:0] mlen;
  logic [STEP_W-1:0] shamt;

  gdad_alu u_alu (
    .op_i  (alu_op),
    .a_i   (acc_q),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  gdad_mlen u_mlen (
    .month_i    (m_q),
    .year_lsb_i (year_q[1:0]),
    .r400_i     (r400_q),
    .len_o      (mlen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q   <= year_d;
    smonth_q <= smonth_d;
    sday_q   <= sday_d;
    add_q    <= add_d;
    m_q      <= m_d;
    r400_q   <= r400_d;
    acc_q    <= acc_d;
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    year_d   = year_q;
    smonth_d = smonth_q;
    sday_d   = sday_q;
    add_d    = add_q;
    m_d      = m_q;
    r400_d   = r400_q;
    acc_d    = acc_q;
    shamt    = STEP_W'(MOD_STEPS - 1) - step_q;
    alu_op   = ALU_SUB;
    alu_b    = ACC_W'(mlen);

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          year_d   = in_i.start_year;
          smonth_d = in_i.start_month;
          sday_d   = in_i.start_day;
          add_d    = in_i.days_to_add;
          acc_d    = ACC_W'(in_i.start_year);
          step_d   = '0;
          state_d  = ST_MOD;
        end
      end
      ST_MOD: begin
        // restoring reduction of the year by 400 times a power of two
        alu_op = ALU_SUB;
        alu_b  = CYCLE_400 << shamt;
        if (!alu_res.borrow) begin
          acc_d = alu_res.res;
        end
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          r400_d  = alu_res.borrow ? acc_q[R400_W-1:0] : alu_res.res[R400_W-1:0];
          acc_d   = ACC_W'(sday_q);
          m_d     = JAN;
          state_d = ST_DOY;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DOY: begin
        alu_op = ALU_ADD;
        alu_b  = ACC_W'(mlen);
        if (m_q < smonth_q) begin
          acc_d = alu_res.res;
          m_d   = m_q + MONTH_W'(1);
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        alu_op  = ALU_ADD;
        alu_b   = ACC_W'(add_q);
        acc_d   = alu_res.res;
        m_d     = JAN;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        alu_op = ALU_SUB;
        alu_b  = ACC_W'(mlen);
        if (alu_res.borrow || alu_res.zero) begin
          state_d = ST_OUT;
        end else begin
          acc_d = alu_res.res;
          if (m_q == DEC) begin
            m_d    = JAN;
            year_d = year_q + YEAR_W'(1);
            if ((year_q == YEAR_MAX) || (r400_q == R400_LAST)) begin
              r400_d = '0;
            end else begin
              r400_d = r400_q + R400_W'(1);
            end
          end else begin
            m_d = m_q + MONTH_W'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_OUT);
  assign out_o.result_year  = year_q;
  assign out_o.result_month = m_q;
  assign out_o.result_day   = acc_q[DAY_W-1:0];

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input still ready after a beat was taken");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.result_month >= JAN) && (out_o.result_month <= DEC)))
    else $error("result month out of range");

  a_r400_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (r400_q <= R400_LAST))
    else $error("year residue out of range");

endmodule

// ===== dv/gdad_tb_pkg.sv =====
// calendar predictor and result scoreboard for the date adder testbench
package gdad_tb_pkg;
  import gdad_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } cal_date_t;

  function automatic bit is_leap(logic [YEAR_W-1:0] y);
    int unsigned yy;
    yy = y;
    return (yy % 400 == 0) || (yy % 4 == 0 && yy % 100 != 0);
  endfunction

  // months outside 1..12 have no days
  function automatic int unsigned month_length(logic [YEAR_W-1:0] y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  class date_ledger;
    cal_date_t   pending_dates[$];
    int unsigned bad_count;

    function cal_date_t later_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] mo,
                                   logic [DAY_W-1:0] d, logic [ADD_W-1:0] n);
      int unsigned left;
      int unsigned m;
      cal_date_t   r;
      left = d;
      for (int k = 1; k < int'(mo); k++) left += month_length(y, k);
      left += n;
      m = 1;
      while (left > month_length(y, m)) begin
        left -= month_length(y, m);
        if (m == 12) begin
          m = 1;
          y = y + 1'b1;
        end else begin
          m++;
        end
      end
      r.year  = y;
      r.month = MONTH_W'(m);
      r.day   = DAY_W'(left);
      return r;
    endfunction

    function void report(string what, cal_date_t want, cal_date_t got);
      bad_count++;
      if (bad_count <= 10)
        $display("%s: expected %0d-%0d-%0d got %0d-%0d-%0d", what,
                 want.year, want.month, want.day, got.year, got.month, got.day);
    endfunction

    function void note_start(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                             logic [DAY_W-1:0] d, logic [ADD_W-1:0] n);
      pending_dates.push_back(later_date(y, m, d, n));
    endfunction

    function void check_sum(cal_date_t got);
      cal_date_t want;
      if (pending_dates.size() == 0) begin
        report("unexpected result beat", got, got);
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day)
        report("date mismatch", want, got);
    endfunction

    function bit all_clean();
      while (pending_dates.size() != 0)
        report("missing result", pending_dates.pop_front(), '0);
      return bad_count == 0;
    endfunction
  endclass

endpackage

// ===== dv/tb_gregorian_date_add_days.sv =====
// top-level testbench for the date adder: random handshakes, predicted dates checked per beat
module tb_gregorian_date_add_days;
  timeunit 1ns;
  timeprecision 1ps;
  import gdad_pkg::*;
  import gdad_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   in_calm;
  bit   out_calm;

  date_ledger ledger;

  gdad_in_if  in_bus ();
  gdad_out_if out_bus ();

  gregorian_date_add_days uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  task automatic push_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
                           input logic [DAY_W-1:0] d, input logic [ADD_W-1:0] n);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.start_year  <= y;
    in_bus.start_month <= m;
    in_bus.start_day   <= d;
    in_bus.days_to_add <= n;
    do @(posedge clk_i); while (!in_bus.ready);
    ledger.note_start(y, m, d, n);
  endtask

  function automatic void random_date(output logic [YEAR_W-1:0] y,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [DAY_W-1:0] d,
                                      output logic [ADD_W-1:0] n);
    case ($urandom_range(0, 9))
      0:       y = YEAR_W'($urandom_range(0, 16383));
      1:       y = YEAR_W'($urandom_range(16300, 16383));
      default: y = YEAR_W'($urandom_range(1, 9999));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      m = MONTH_W'($urandom_range(0, 15));
      d = DAY_W'($urandom_range(0, 31));
    end else begin
      m = MONTH_W'($urandom_range(1, 12));
      d = DAY_W'($urandom_range(1, month_length(y, m)));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = ADD_W'($urandom_range(0, 32767));
      4, 5, 6:    n = ADD_W'($urandom_range(0, 400));
      7:          n = ADD_W'($urandom_range(0, 40));
      default:    n = ADD_W'($urandom_range(32000, 32767));
    endcase
  endfunction

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // result side
  initial begin
    int unsigned stall;
    int unsigned beats;
    cal_date_t   got;
    beats = 0;
    out_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (beats % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
      got.year  = out_bus.result_year;
      got.month = out_bus.result_month;
      got.day   = out_bus.result_day;
      ledger.check_sum(got);
      beats++;
    end
  end

  initial begin
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [ADD_W-1:0]   n;
    ledger = new;
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.start_year  <= '0;
    in_bus.start_month <= '0;
    in_bus.start_day   <= '0;
    in_bus.days_to_add <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes and calendar corner cases
    push_date(14'd1,     4'd1,  5'd1,  15'd0);
    push_date(14'd9999,  4'd12, 5'd31, 15'd32767);
    push_date(14'd0,     4'd1,  5'd1,  15'd0);
    push_date(14'd16383, 4'd12, 5'd31, 15'd32767);
    push_date(14'd16383, 4'd12, 5'd31, 15'd1);
    push_date(14'd2024,  4'd1,  5'd0,  15'd0);
    push_date(14'd2024,  4'd0,  5'd5,  15'd10);
    push_date(14'd2023,  4'd13, 5'd1,  15'd0);
    push_date(14'd2023,  4'd15, 5'd31, 15'd32767);
    push_date(14'd2023,  4'd14, 5'd20, 15'd3);
    push_date(14'd2023,  4'd2,  5'd31, 15'd0);
    push_date(14'd2000,  4'd2,  5'd28, 15'd1);
    push_date(14'd1900,  4'd2,  5'd28, 15'd1);
    push_date(14'd2024,  4'd2,  5'd28, 15'd1);
    push_date(14'd2023,  4'd12, 5'd31, 15'd1);
    push_date(14'd2100,  4'd2,  5'd29, 15'd0);
    push_date(14'd1,     4'd1,  5'd0,  15'd5);
    push_date(14'd8191,  4'd6,  5'd15, 15'd16384);
    push_date(14'd4000,  4'd3,  5'd1,  15'd16383);
    push_date(14'd9999,  4'd1,  5'd1,  15'd365);

    for (int i = 0; i < 520; i++) begin
      if (i % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
      random_date(y, m, d, n);
      push_date(y, m, d, n);
    end
    in_bus.valid <= 1'b0;

    while (ledger.pending_dates.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    if (ledger.all_clean())
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
